FILE: rtl/lcd_4bit_nibble_write_sequencer_core_macros.svh
// Assertion macros shared by the checker.
`ifndef LCD_4BIT_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH
`define LCD_4BIT_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define LCD4_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LCD4_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lcd4_pkg.sv
`timescale 1ns / 1ps
package lcd4_pkg;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned IdxWidth     = 5;

  localparam logic [1:0] REG_SETUP   = 2'd0;
  localparam logic [1:0] REG_PULSE   = 2'd1;
  localparam logic [1:0] REG_POWERUP = 2'd2;

  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  localparam logic [15:0] SETUP_RESET   = 16'd2000;
  localparam logic [15:0] PULSE_RESET   = 16'd2000;
  localparam logic [19:0] POWERUP_RESET = 20'd100000;

  localparam logic [7:0] INIT_WAKE_BYTE = 8'h30;
  localparam logic [7:0] INIT_MODE_BYTE = 8'h20;
  localparam logic [7:0] HIGH_MASK      = 8'hF0;
  localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h06, 8'h01, 8'h0C};

  typedef enum logic [1:0] {
    RUN_CMD  = 2'd0,
    RUN_DATA = 2'd1,
    RUN_INIT = 2'd2
  } run_t;

  typedef enum logic [1:0] {
    HOLD_SETUP   = 2'd0,
    HOLD_PULSE   = 2'd1,
    HOLD_POWERUP = 2'd2,
    HOLD_ZERO    = 2'd3
  } hold_sel_t;

  typedef struct packed {
    run_t       kind;
    logic [7:0] value;
  } entry_t;

  typedef struct packed {
    logic [15:0] setup_ticks;
    logic [15:0] pulse_ticks;
    logic [19:0] powerup_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       en;
    hold_sel_t  hold_sel;
    logic       last;
  } ev_t;

  // Pin event number idx of a run of the given kind.
  function automatic ev_t lcd4_event(run_t kind, logic [IdxWidth-1:0] idx,
                                     logic [7:0] value);
    ev_t                 ev;
    logic [IdxWidth-1:0] m;
    logic [7:0]          b;
    m  = '0;
    b  = '0;
    ev = '{nib: 4'h0, en: 1'b0, hold_sel: HOLD_ZERO, last: 1'b0};
    if (kind == RUN_INIT) begin
      if (idx == IdxWidth'(0)) begin
        ev.hold_sel = HOLD_POWERUP;
      end else if (idx <= IdxWidth'(8)) begin
        m  = idx - IdxWidth'(1);
        b  = (m[IdxWidth-1:1] == 4'd3) ? INIT_MODE_BYTE : INIT_WAKE_BYTE;
        ev.nib      = b[7:4];
        ev.en       = m[0];
        ev.hold_sel = m[0] ? HOLD_PULSE : HOLD_SETUP;
      end else if (idx <= IdxWidth'(24)) begin
        m  = idx - IdxWidth'(9);
        b  = INIT_BYTES[m[3:2]];
        ev.nib      = m[1] ? b[3:0] : b[7:4];
        ev.en       = m[0];
        ev.hold_sel = m[0] ? HOLD_PULSE : HOLD_SETUP;
      end else begin
        b  = INIT_BYTES[3];
        ev.nib  = b[3:0];
        ev.last = 1'b1;
      end
    end else begin
      if (idx >= IdxWidth'(4)) begin
        ev.nib  = value[3:0];
        ev.last = 1'b1;
      end else begin
        b  = value & HIGH_MASK;
        ev.nib      = idx[1] ? value[3:0] : b[7:4];
        ev.en       = idx[0];
        ev.hold_sel = idx[0] ? HOLD_PULSE : HOLD_SETUP;
      end
    end
    return ev;
  endfunction

endpackage

FILE: rtl/lcd4_front.sv
`timescale 1ns / 1ps
module lcd4_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          op,
  input  logic [7:0]          value,
  input  logic                q_full,
  output logic                push,
  output lcd4_pkg::entry_t    push_entry
);
  import lcd4_pkg::*;

  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Unused op codes are accepted and dropped.
  always_comb begin
    push       = 1'b0;
    push_entry = '{kind: RUN_CMD, value: value};
    case (op)
      OP_CMD: begin
        push            = accept;
        push_entry.kind = RUN_CMD;
      end
      OP_DATA: begin
        push            = accept;
        push_entry.kind = RUN_DATA;
      end
      OP_INIT: begin
        push            = accept;
        push_entry.kind = RUN_INIT;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end
endmodule

FILE: rtl/lcd4_queue.sv
`timescale 1ns / 1ps
module lcd4_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lcd4_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output lcd4_pkg::entry_t head
);
  import lcd4_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule

FILE: rtl/lcd4_back.sv
`timescale 1ns / 1ps
module lcd4_back (
  input  logic             clk,
  input  logic             rst,
  input  lcd4_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  lcd4_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       data_pins,
  output logic             rs_pin,
  output logic             en_pin,
  output logic [19:0]      hold_ticks,
  output logic             last
);
  import lcd4_pkg::*;

  logic [IdxWidth-1:0] idx;
  logic [IdxWidth-1:0] idx_next;
  logic                load;
  ev_t                 ev;
  logic [19:0]         hold;

  assign load = head_valid && (!out_valid || !out_stall);
  assign ev   = lcd4_event(head.kind, idx, head.value);
  assign pop  = load && ev.last;

  always_comb begin
    idx_next = ev.last ? '0 : idx + IdxWidth'(1);
    case (ev.hold_sel)
      HOLD_SETUP:   hold = {4'h0, cfg.setup_ticks};
      HOLD_PULSE:   hold = {4'h0, cfg.pulse_ticks};
      HOLD_POWERUP: hold = cfg.powerup_ticks;
      default:      hold = 20'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= idx_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_pins  <= ev.nib;
      rs_pin     <= (head.kind == RUN_DATA);
      en_pin     <= ev.en;
      hold_ticks <= hold;
      last       <= ev.last;
    end
  end
endmodule

FILE: rtl/lcd_4bit_nibble_write_sequencer_core.sv
`timescale 1ns / 1ps
// A command or data write gives 5 pin events at one per cycle while out_stall is low; an init run gives 26.
// The first event of a transaction passes through the queue and then the output registers.
// The event sequencer sends every event of a run before it pops the next entry from the queue.
// A two-entry queue lets the next transaction be accepted while a run is going out.
// Synchronous reset empties the queue and output and restores the tick registers.
module lcd_4bit_nibble_write_sequencer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcd4_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [7:0]                        value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        data_pins,
  output logic                              rs_pin,
  output logic                              en_pin,
  output logic [19:0]                       hold_ticks,
  output logic                              last
);
  import lcd4_pkg::*;

  cfg_t       cfg;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       q_full;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       head_valid;
  entry_t     head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks   <= SETUP_RESET;
      cfg.pulse_ticks   <= PULSE_RESET;
      cfg.powerup_ticks <= POWERUP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SETUP:   cfg.setup_ticks   <= pwdata[15:0];
        REG_PULSE:   cfg.pulse_ticks   <= pwdata[15:0];
        REG_POWERUP: cfg.powerup_ticks <= pwdata[19:0];
        default:     cfg               <= cfg;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SETUP:   prdata = {16'h0, cfg.setup_ticks};
      REG_PULSE:   prdata = {16'h0, cfg.pulse_ticks};
      REG_POWERUP: prdata = {12'h0, cfg.powerup_ticks};
      default:     prdata = 32'h0;
    endcase
  end

  lcd4_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lcd4_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  lcd4_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_pins  (data_pins),
    .rs_pin     (rs_pin),
    .en_pin     (en_pin),
    .hold_ticks (hold_ticks),
    .last       (last)
  );
endmodule

FILE: rtl/lcd4_checker.sv
`timescale 1ns / 1ps
`include "lcd_4bit_nibble_write_sequencer_core_macros.svh"
module lcd4_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  data_pins,
  input logic        en_pin,
  input logic [19:0] hold_ticks,
  input logic        last
);
  // The closing event of a run drops enable and holds for no ticks.
  `LCD4_ASSERT_RUN(a_last_closes, out_valid && last |-> !en_pin && hold_ticks == 20'd0, "closing event malformed")
  // An enable pulse is never the end of a run.
  `LCD4_ASSERT_RUN(a_pulse_not_last, out_valid && en_pin |-> !last, "run ended on enable high")
  // A stalled event keeps its data pins and hold ticks.
  `LCD4_ASSERT_RUN(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(data_pins) && $stable(hold_ticks), "stalled event changed")
  // Reset leaves no event on the output.
  `LCD4_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "output valid after reset")
  `LCD4_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
endmodule

bind lcd_4bit_nibble_write_sequencer_core lcd4_checker u_lcd4_checker (
  .clk        (clk),
  .rst        (rst),
  .pready     (pready),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .data_pins  (data_pins),
  .en_pin     (en_pin),
  .hold_ticks (hold_ticks),
  .last       (last)
);
